// ----- sv/bfd_pkg.sv -----
// shared types and constants for the bin frame deframer
package bfd_pkg;

   localparam logic [7:0] CHAR_DOLLAR = 8'h24;
   localparam logic [7:0] CHAR_B      = 8'h42;
   localparam logic [7:0] CHAR_I      = 8'h49;
   localparam logic [7:0] CHAR_N      = 8'h4E;
   localparam logic [7:0] CHAR_CR     = 8'h0D;
   localparam logic [7:0] CHAR_LF     = 8'h0A;

   localparam int unsigned BYTE_W      = 8;
   localparam int unsigned LEN_W       = 16;
   localparam int unsigned REM_W       = 17;
   localparam int unsigned RSP_FIELD_W = 8 + 8 + 1 + 16;
   localparam int unsigned RSP_TDATA_W = ((RSP_FIELD_W + 7) / 8) * 8;

   localparam logic [REM_W-1:0] CHECKSUM_BYTES = 17'd2;

   typedef enum logic [3:0] {
      PH_HUNT   = 4'd0,
      PH_DOLLAR = 4'd1,
      PH_B      = 4'd2,
      PH_I      = 4'd3,
      PH_ID     = 4'd4,
      PH_ZERO   = 4'd5,
      PH_LEN_LO = 4'd6,
      PH_LEN_HI = 4'd7,
      PH_DATA   = 4'd8,
      PH_CR     = 4'd9,
      PH_LF     = 4'd10
   } phase_type;

   typedef enum logic {
      KIND_BYTE = 1'b0,
      KIND_END  = 1'b1
   } kind_type;

   typedef struct packed {
      kind_type          result_kind;
      logic [7:0]        frame_id;
      logic [7:0]        out_byte;
      logic              frame_good;
      logic [LEN_W-1:0]  payload_length;
   } result_type;

endpackage

// ----- sv/bfd_input_stage.sv -----
// input register holding one received byte
module bfd_input_stage (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [bfd_pkg::BYTE_W-1:0] req_tdata,
   input  logic                       take,
   output logic                       held_valid,
   output logic [bfd_pkg::BYTE_W-1:0] held_byte
);

   logic                       valid_ff, valid_in;
   logic [bfd_pkg::BYTE_W-1:0] byte_ff, byte_in;
   logic                       accept;

   assign req_tready = !valid_ff || take;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      valid_in = valid_ff;
      byte_in  = byte_ff;
      if (accept) begin
         valid_in = 1'b1;
         byte_in  = req_tdata;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      byte_ff <= byte_in;
   end

   assign held_valid = valid_ff;
   assign held_byte  = byte_ff;

endmodule

// ----- sv/bfd_parser.sv -----
// header hunt, payload pass-through and epilogue check state machine
module bfd_parser (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       step_valid,
   input  logic [bfd_pkg::BYTE_W-1:0] step_byte,
   input  logic                       step_fire,
   output logic                       emit,
   output bfd_pkg::result_type        result
);

   bfd_pkg::phase_type              phase_ff, phase_in;
   logic [7:0]                      id_ff, id_in;
   logic [bfd_pkg::LEN_W-1:0]       len_ff, len_in;
   logic [bfd_pkg::REM_W-1:0]       rem_ff, rem_in;
   logic [bfd_pkg::REM_W-1:0]       rem_dec;
   bfd_pkg::phase_type              restart;
   logic                            found;

   always_comb begin
      restart  = (step_byte == bfd_pkg::CHAR_DOLLAR) ? bfd_pkg::PH_DOLLAR : bfd_pkg::PH_HUNT;
      rem_dec  = rem_ff - 17'd1;
      phase_in = phase_ff;
      id_in    = id_ff;
      len_in   = len_ff;
      rem_in   = rem_ff;
      found    = 1'b0;
      result.result_kind    = bfd_pkg::KIND_BYTE;
      result.frame_id       = id_ff;
      result.out_byte       = 8'd0;
      result.frame_good     = 1'b0;
      result.payload_length = len_ff;
      case (phase_ff)
         bfd_pkg::PH_DOLLAR: begin
            phase_in = (step_byte == bfd_pkg::CHAR_B) ? bfd_pkg::PH_B : restart;
         end
         bfd_pkg::PH_B: begin
            phase_in = (step_byte == bfd_pkg::CHAR_I) ? bfd_pkg::PH_I : restart;
         end
         bfd_pkg::PH_I: begin
            phase_in = (step_byte == bfd_pkg::CHAR_N) ? bfd_pkg::PH_ID : restart;
         end
         bfd_pkg::PH_ID: begin
            id_in    = step_byte;
            phase_in = bfd_pkg::PH_ZERO;
         end
         bfd_pkg::PH_ZERO: begin
            if (step_byte == 8'd0) begin
               phase_in = bfd_pkg::PH_LEN_LO;
            end else if (id_ff == bfd_pkg::CHAR_DOLLAR && step_byte == bfd_pkg::CHAR_B) begin
               phase_in = bfd_pkg::PH_B;
            end else begin
               phase_in = restart;
            end
         end
         bfd_pkg::PH_LEN_LO: begin
            len_in   = {8'd0, step_byte};
            phase_in = bfd_pkg::PH_LEN_HI;
         end
         bfd_pkg::PH_LEN_HI: begin
            len_in   = {step_byte, len_ff[7:0]};
            rem_in   = {1'b0, step_byte, len_ff[7:0]} + bfd_pkg::CHECKSUM_BYTES;
            phase_in = bfd_pkg::PH_DATA;
         end
         bfd_pkg::PH_DATA: begin
            found           = 1'b1;
            result.out_byte = step_byte;
            rem_in          = rem_dec;
            if (rem_dec == '0) begin
               phase_in = bfd_pkg::PH_CR;
            end
         end
         bfd_pkg::PH_CR: begin
            if (step_byte == bfd_pkg::CHAR_CR) begin
               phase_in = bfd_pkg::PH_LF;
            end else begin
               found              = 1'b1;
               result.result_kind = bfd_pkg::KIND_END;
               phase_in           = restart;
            end
         end
         bfd_pkg::PH_LF: begin
            found              = 1'b1;
            result.result_kind = bfd_pkg::KIND_END;
            if (step_byte == bfd_pkg::CHAR_LF) begin
               result.frame_good = 1'b1;
               phase_in          = bfd_pkg::PH_HUNT;
            end else begin
               phase_in = restart;
            end
         end
         default: begin
            phase_in = restart;
         end
      endcase
      emit = step_valid && found;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= bfd_pkg::PH_HUNT;
         id_ff    <= 8'd0;
         len_ff   <= '0;
         rem_ff   <= '0;
      end else if (step_fire) begin
         phase_ff <= phase_in;
         id_ff    <= id_in;
         len_ff   <= len_in;
         rem_ff   <= rem_in;
      end
   end

   a_emit_phase: assert property (@(posedge clock) disable iff (reset)
      emit |-> (phase_ff == bfd_pkg::PH_DATA || phase_ff == bfd_pkg::PH_CR ||
                phase_ff == bfd_pkg::PH_LF))
      else $error("result produced outside payload or epilogue");

   a_data_count: assert property (@(posedge clock) disable iff (reset)
      phase_ff == bfd_pkg::PH_DATA |-> rem_ff != '0)
      else $error("payload phase with no bytes left");

   a_len_load: assert property (@(posedge clock) disable iff (reset)
      (step_fire && phase_ff == bfd_pkg::PH_LEN_HI) |=>
         (phase_ff == bfd_pkg::PH_DATA && rem_ff >= bfd_pkg::CHECKSUM_BYTES))
      else $error("length load did not arm payload count");

endmodule

// ----- sv/bfd_output_stage.sv -----
// result register feeding the output stream
module bfd_output_stage (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            load,
   input  bfd_pkg::result_type             result,
   output logic                            free,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [bfd_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   output logic [0:0]                      rsp_tuser
);

   logic                valid_ff, valid_in;
   bfd_pkg::result_type data_ff, data_in;

   assign free = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (load) begin
         valid_in = 1'b1;
         data_in  = result;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tuser  = data_ff.result_kind;
   assign rsp_tdata  = {{(bfd_pkg::RSP_TDATA_W - bfd_pkg::RSP_FIELD_W){1'b0}},
                        data_ff.payload_length, data_ff.frame_good,
                        data_ff.out_byte, data_ff.frame_id};

endmodule

// ----- sv/bin_frame_deframer_unit.sv -----
// top level of the bin frame deframer
// path: an accepted byte passes through the input register, then the result register, to its result item
// throughput: one byte per cycle, except that a byte that produces a result stalls while the result register is full
// reset: synchronous, active high; clears both stage valid bits and returns to hunting for '$'
// held id, length and byte count reset to zero
module bin_frame_deframer_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [bfd_pkg::BYTE_W-1:0]      req_tdata,  // in_byte
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [bfd_pkg::RSP_TDATA_W-1:0] rsp_tdata,  // frame_id, out_byte, frame_good, payload_length
   output logic [0:0]                      rsp_tuser   // result_kind
);

   logic                       held_valid;
   logic [bfd_pkg::BYTE_W-1:0] held_byte;
   logic                       take;
   logic                       emit;
   logic                       free;
   bfd_pkg::result_type        result;

   assign take = held_valid && (!emit || free);

   bfd_input_stage u_input (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .take       (take),
      .held_valid (held_valid),
      .held_byte  (held_byte)
   );

   bfd_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .step_valid (held_valid),
      .step_byte  (held_byte),
      .step_fire  (take),
      .emit       (emit),
      .result     (result)
   );

   bfd_output_stage u_output (
      .clock      (clock),
      .reset      (reset),
      .load       (take && emit),
      .result     (result),
      .free       (free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
